/* hw/rtl/scale_weight_frame_parser_assert.svh */
// Assertion macros for the scale weight frame parser.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef SCALE_WEIGHT_FRAME_PARSER_ASSERT_SVH
`define SCALE_WEIGHT_FRAME_PARSER_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define SWFP_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swfp: same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define SWFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swfp: next-cycle check failed");

`endif

/* hw/rtl/swfp_pkg.sv */
// Shared types, character constants and helper functions of the frame parser.
// No dependencies; imported by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package swfp_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_BUFFER_DEPTH  = 32;
  localparam int DEF_CHECKSUM_SPAN = 8;

  // Framing characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ETX    = 8'h03;
  localparam logic [7:0] CH_STX    = 8'h02;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NIBBLE = 8'h0F;

  // Fixed position of the units digit for the CR fixed-layout model; the higher
  // digits sit at the positions below it
  localparam int FIXED_TOP_POS = 6;

  typedef enum logic [2:0] {
    MODEL_LF_STX   = 3'd0,
    MODEL_CR_A     = 3'd1,
    MODEL_CR_B     = 3'd2,
    MODEL_ETX_XOR  = 3'd3,
    MODEL_CR_FIXED = 3'd4
  } model_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_DIGIT = 3'd1,
    ST_UNSETTLED = 3'd2,
    ST_CHECKSUM  = 3'd3,
    ST_FRAME     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SUM_RD,
    S_SUM_EV,
    S_DIG_RD,
    S_DIG_EV,
    S_SETTLE,
    S_FINISH
  } state_t;

  // Frame store control from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr;
  } store_ctl_t;

  // One result transaction
  typedef struct packed {
    logic [4:0][3:0] digits;
    logic            upd;
    status_t         status;
  } result_t;

  // True when the character closes a frame of the given model
  function automatic logic end_match(input logic [2:0] model, input logic [7:0] c);
    logic hit;
    case (model)
      MODEL_LF_STX:   hit = (c == CH_LF);
      MODEL_CR_A:     hit = (c == CH_CR);
      MODEL_CR_B:     hit = (c == CH_CR);
      MODEL_ETX_XOR:  hit = (c == CH_ETX);
      MODEL_CR_FIXED: hit = (c == CH_CR);
      default:        hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Smallest end position that a frame of each model may have
  function automatic logic [3:0] min_len(input logic [2:0] model);
    logic [3:0] len;
    case (model)
      MODEL_LF_STX:   len = 4'd12;
      MODEL_CR_A:     len = 4'd5;
      MODEL_CR_B:     len = 4'd8;
      MODEL_ETX_XOR:  len = 4'd8;
      MODEL_CR_FIXED: len = 4'd7;
      default:        len = 4'd0;
    endcase
    return len;
  endfunction

  // Distance of the units digit back from the end character
  function automatic logic [3:0] back_off(input logic [2:0] model);
    logic [3:0] off;
    case (model)
      MODEL_LF_STX:  off = 4'd8;
      MODEL_CR_A:    off = 4'd1;
      MODEL_CR_B:    off = 4'd3;
      MODEL_ETX_XOR: off = 4'd4;
      default:       off = 4'd0;
    endcase
    return off;
  endfunction

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = (c - CH_ZERO) & CH_NIBBLE;
    return d[3:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= (CH_ZERO + 8'd9));
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/swfp_store.sv */
// Frame store: byte memory with one write port, one registered read port and per-entry valid bits.
// Depends on swfp_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module swfp_store #(
  parameter int BUFFER_DEPTH = 32,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  swfp_pkg::store_ctl_t   ctl,
  input  logic [AW-1:0]          wr_addr,
  input  logic [7:0]             wr_data,
  input  logic [AW-1:0]          rd_addr,
  output logic [7:0]             rd_data
);
  import swfp_pkg::*;

  logic [7:0]              mem [BUFFER_DEPTH];
  logic [BUFFER_DEPTH-1:0] vld_r;
  logic [7:0]              rd_data_r;

  // Write port and registered read; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : 8'h00;
    end
  end

  // Valid bits: drop all on reset or clear, set on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hw/rtl/swfp_ctrl.sv */
// Frame sequencer: stores bytes, then walks the frame store one read at a time
// through the shared byte evaluator. Depends on swfp_pkg and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
`include "scale_weight_frame_parser_assert.svh"

module swfp_ctrl #(
  parameter int BUFFER_DEPTH  = 32,
  parameter int CHECKSUM_SPAN = 8,
  localparam int AW = $clog2(BUFFER_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [2:0]           model,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  output swfp_pkg::store_ctl_t st_ctl,
  output logic [AW-1:0]        st_wr_addr,
  output logic [AW-1:0]        st_rd_addr,
  output logic [7:0]           st_wr_data,
  input  logic [7:0]           st_rd_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output swfp_pkg::result_t    res
);
  import swfp_pkg::*;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   wr_idx_r, wr_idx_nxt;
  logic [AW-1:0]   p_r, p_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic [2:0]      k_r, k_nxt;
  logic [7:0]      prev_r, prev_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic [3:0]      hi_r, hi_nxt;
  logic [4:0][3:0] digits_r, digits_nxt;
  logic [3:0]      prev_top_r, prev_top_nxt;
  status_t         status_r, status_nxt;
  logic            upd_r, upd_nxt;

  logic            in_acc;
  logic            is_end;
  logic            short_f;
  logic [AW-1:0]   p_sel;
  logic [AW-1:0]   dig_base;
  logic [7:0]      cur;
  logic            pair_hit;
  logic            scan_fail;
  logic            stx_fail;
  logic            sum_last;
  logic            sum_bad;
  logic            dig_bad;
  logic            dig_last;
  logic            top_same;
  logic            cr_model;

  // Shared byte evaluator: decisions on the byte just read
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign is_end   = end_match(model, in_byte);
  assign short_f  = wr_idx_r < AW'(min_len(model));
  assign p_sel    = (state_r == S_IDLE) ? wr_idx_r : p_r;
  assign dig_base = (model == MODEL_CR_FIXED) ? AW'(FIXED_TOP_POS)
                                              : p_sel - AW'(back_off(model));
  assign cur      = st_rd_data;
  assign pair_hit = (cnt_r != '0) && (prev_r == CH_CR) && (cur == CH_LF);
  assign stx_fail = (cnt_r == '0) && (cur != CH_STX);
  assign scan_fail = !pair_hit && (stx_fail || (cnt_r == p_r) || (cur == 8'h00));
  assign sum_last = cnt_r == AW'(CHECKSUM_SPAN + 2);
  assign sum_bad  = sum_last && ({hi_r, cur[3:0]} != sum_r);
  assign dig_bad  = (model != MODEL_LF_STX) && !is_digit(cur);
  assign dig_last = k_r == 3'd4;
  assign top_same = prev_top_r == digits_r[4];
  assign cr_model = (model == MODEL_CR_A) || (model == MODEL_CR_B) ||
                    (model == MODEL_CR_FIXED);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && is_end) begin
          if (short_f) begin
            state_nxt = S_FINISH;
          end else if (model == MODEL_LF_STX) begin
            state_nxt = S_SCAN_RD;
          end else if (model == MODEL_ETX_XOR) begin
            state_nxt = S_SUM_RD;
          end else begin
            state_nxt = S_DIG_RD;
          end
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        if (pair_hit) begin
          state_nxt = S_DIG_RD;
        end else if (scan_fail) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SUM_RD: state_nxt = S_SUM_EV;
      S_SUM_EV: begin
        if (stx_fail || sum_bad) begin
          state_nxt = S_FINISH;
        end else if (sum_last) begin
          state_nxt = S_DIG_RD;
        end else begin
          state_nxt = S_SUM_RD;
        end
      end
      S_DIG_RD: state_nxt = S_DIG_EV;
      S_DIG_EV: begin
        if (dig_bad) begin
          state_nxt = S_FINISH;
        end else if (dig_last) begin
          state_nxt = S_SETTLE;
        end else begin
          state_nxt = S_DIG_RD;
        end
      end
      S_SETTLE: state_nxt = S_FINISH;
      S_FINISH: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    st_ctl.wr_en  = in_acc;
    st_ctl.rd_en  = (state_r == S_SCAN_RD) || (state_r == S_SUM_RD) ||
                    (state_r == S_DIG_RD);
    st_ctl.clr    = (state_r == S_SETTLE) && (model == MODEL_CR_FIXED) && top_same;
    st_wr_addr    = wr_idx_r;
    st_wr_data    = in_byte;
    st_rd_addr    = addr_r;
    res_valid     = (state_r == S_FINISH);
    res.digits    = digits_r;
    res.upd       = upd_r;
    res.status    = status_r;
  end

  // Datapath next values
  always_comb begin
    wr_idx_nxt   = wr_idx_r;
    p_nxt        = p_r;
    addr_nxt     = addr_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    prev_nxt     = prev_r;
    sum_nxt      = sum_r;
    hi_nxt       = hi_r;
    digits_nxt   = digits_r;
    prev_top_nxt = prev_top_r;
    status_nxt   = status_r;
    upd_nxt      = upd_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!is_end) begin
            // advance, holding on the last slot when full
            if (wr_idx_r != AW'(BUFFER_DEPTH - 1)) begin
              wr_idx_nxt = wr_idx_r + 1'b1;
            end
          end else begin
            wr_idx_nxt = '0;
            p_nxt      = wr_idx_r;
            cnt_nxt    = '0;
            k_nxt      = '0;
            sum_nxt    = '0;
            upd_nxt    = 1'b0;
            status_nxt = short_f ? ST_FRAME : ST_OK;
            addr_nxt   = ((model == MODEL_LF_STX) || (model == MODEL_ETX_XOR)) ? '0
                                                                                : dig_base;
          end
        end
      end
      S_SCAN_EV: begin
        prev_nxt = cur;
        cnt_nxt  = cnt_r + 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (pair_hit) begin
          addr_nxt = dig_base;
        end else if (scan_fail) begin
          status_nxt = ST_FRAME;
        end
      end
      S_SUM_EV: begin
        cnt_nxt = cnt_r + 1'b1;
        if ((cnt_r != '0) && (cnt_r <= AW'(CHECKSUM_SPAN))) begin
          sum_nxt = sum_r ^ cur;
        end
        if (cnt_r == AW'(CHECKSUM_SPAN + 1)) begin
          hi_nxt = cur[3:0];
        end
        // pick the next address: span bytes, then the two checksum characters
        if (cnt_nxt == AW'(CHECKSUM_SPAN + 1)) begin
          addr_nxt = p_r - AW'(2);
        end else if (cnt_nxt == AW'(CHECKSUM_SPAN + 2)) begin
          addr_nxt = p_r - AW'(1);
        end else begin
          addr_nxt = cnt_nxt;
        end
        if (stx_fail) begin
          status_nxt = ST_FRAME;
        end else if (sum_bad) begin
          status_nxt = ST_CHECKSUM;
        end else if (sum_last) begin
          addr_nxt = dig_base;
        end
      end
      S_DIG_EV: begin
        // write the digit before it is checked
        digits_nxt[k_r] = digit_of(cur);
        k_nxt           = k_r + 1'b1;
        addr_nxt        = addr_r - 1'b1;
        if (dig_bad) begin
          status_nxt = ST_BAD_DIGIT;
        end
      end
      S_SETTLE: begin
        if (cr_model) begin
          if (!top_same) begin
            prev_top_nxt = digits_r[4];
            status_nxt   = ST_UNSETTLED;
          end else begin
            upd_nxt = 1'b1;
          end
        end else if (model == MODEL_ETX_XOR) begin
          upd_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      wr_idx_r   <= '0;
      digits_r   <= '0;
      prev_top_r <= '0;
      status_r   <= ST_OK;
      upd_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      wr_idx_r   <= wr_idx_nxt;
      digits_r   <= digits_nxt;
      prev_top_r <= prev_top_nxt;
      status_r   <= status_nxt;
      upd_r      <= upd_nxt;
    end
  end

  // Working registers of the walk
  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    addr_r <= addr_nxt;
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
    prev_r <= prev_nxt;
    sum_r  <= sum_nxt;
    hi_r   <= hi_nxt;
  end

  // Checks
  `SWFP_ASSERT_NEXT(a_idx_rewind, clk, rst_n, in_acc && is_end, wr_idx_r == '0)
  `SWFP_ASSERT_SAME(a_idx_range, clk, rst_n, 1'b1, wr_idx_r <= AW'(BUFFER_DEPTH - 1))
  `SWFP_ASSERT_SAME(a_upd_ok, clk, rst_n, state_r == S_FINISH, !upd_r || (status_r == ST_OK))
  `SWFP_ASSERT_NEXT(a_hold_result, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res))

endmodule

`default_nettype wire

/* hw/rtl/scale_weight_frame_parser.sv */
// Weighing-scale display frame parser: one serial character per input transaction,
// one result per end character. A byte that does not end a frame is stored and the
// block stays ready. An end character starts a walk over the frame store through its
// single read port, each byte read taking an address state and then an evaluate
// state, followed by a settle state and a state that hands over the result. The ETX
// model first reads the start byte, the checksum span and the two checksum characters,
// and the LF model first runs a CR LF search that reads from position 0 onward.
// Input is held off (in_ready low) for that whole time and while a result waits.
// Depends on swfp_pkg, swfp_store and swfp_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module scale_weight_frame_parser #(
  parameter int BUFFER_DEPTH  = swfp_pkg::DEF_BUFFER_DEPTH,
  parameter int CHECKSUM_SPAN = swfp_pkg::DEF_CHECKSUM_SPAN
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_digit_units,
  output logic [3:0] out_digit_tens,
  output logic [3:0] out_digit_hundreds,
  output logic [3:0] out_digit_thousands,
  output logic [3:0] out_digit_ten_thousands,
  output logic       out_update_display,
  output logic [2:0] out_frame_status
);
  import swfp_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic [2:0]    model_r;
  store_ctl_t    st_ctl;
  logic [AW-1:0] st_wr_addr;
  logic [AW-1:0] st_rd_addr;
  logic [7:0]    st_wr_data;
  logic [7:0]    st_rd_data;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  logic          out_valid_r;
  result_t       out_r;

  // Display model register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r <= MODEL_LF_STX;
    end else if (cfg_wr_en) begin
      model_r <= cfg_wr_data;
    end
  end

  swfp_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (st_ctl),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  swfp_ctrl #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .CHECKSUM_SPAN(CHECKSUM_SPAN)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .model      (model_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_rx_byte),
    .st_ctl     (st_ctl),
    .st_wr_addr (st_wr_addr),
    .st_rd_addr (st_rd_addr),
    .st_wr_data (st_wr_data),
    .st_rd_data (st_rd_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_digit_units         = out_r.digits[0];
  assign out_digit_tens          = out_r.digits[1];
  assign out_digit_hundreds      = out_r.digits[2];
  assign out_digit_thousands     = out_r.digits[3];
  assign out_digit_ten_thousands = out_r.digits[4];
  assign out_update_display      = out_r.upd;
  assign out_frame_status        = out_r.status;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for scale_weight_frame_parser: serial characters go in over
// valid/ready, an in-line predictor works out each frame result and a checker compares.
// Depends on swfp_pkg and the parser RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_top;
  import swfp_pkg::*;

  localparam int DEPTH         = DEF_BUFFER_DEPTH;
  localparam int SPAN          = DEF_CHECKSUM_SPAN;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT   = 5000;
  localparam int MAX_REPORTS   = 10;
  localparam int SEGMENT_CHARS = 90;

  typedef struct packed {
    logic [4:0][3:0] digit;
    logic            upd;
    status_t         status;
  } weight_result_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] out_digit_units;
  logic [3:0] out_digit_tens;
  logic [3:0] out_digit_hundreds;
  logic [3:0] out_digit_thousands;
  logic [3:0] out_digit_ten_thousands;
  logic       out_update_display;
  logic [2:0] out_frame_status;

  // Shadow state of the parser
  logic [7:0] shadow_store [DEPTH];
  int         fill_pos;
  logic [3:0] shadow_digit [5];
  logic [3:0] last_top;
  model_t     cur_model;

  weight_result_t pending_q [$];
  logic [7:0]     frame_buf [$];
  logic [7:0]     top_pick;

  int send_idle_pct;
  int recv_idle_pct;
  int chars_sent;
  int results_seen;
  int mismatch_count;
  int quiet_cycles;

  scale_weight_frame_parser u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_rx_byte              (in_rx_byte),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_digit_units         (out_digit_units),
    .out_digit_tens          (out_digit_tens),
    .out_digit_hundreds      (out_digit_hundreds),
    .out_digit_thousands     (out_digit_thousands),
    .out_digit_ten_thousands (out_digit_ten_thousands),
    .out_update_display      (out_update_display),
    .out_frame_status        (out_frame_status)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  // Load five digits counting down from start; stop at the first bad one when checking
  function automatic bit load_weight(input int start, input bit range_chk);
    logic [7:0] c;
    int k;
    for (k = 0; k < 5; k++) begin
      c = shadow_store[start - k];
      shadow_digit[k] = 4'(c - CH_ZERO);
      if (range_chk && (c < CH_ZERO || c > CH_ZERO + 8'd9)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Refresh only when the top digit repeats; otherwise remember it
  function automatic status_t confirm_top(output bit refresh);
    refresh = 1'b0;
    if (last_top != shadow_digit[4]) begin
      last_top = shadow_digit[4];
      return ST_UNSETTLED;
    end
    refresh = 1'b1;
    return ST_OK;
  endfunction

  // Store one character; on an end character, queue the frame result
  function automatic void predict_char(input logic [7:0] c);
    int             p;
    int             i;
    bit             closes;
    bit             pair;
    bit             refresh;
    logic [7:0]     sum;
    logic [7:0]     got;
    status_t        st;
    weight_result_t res;
    p = (fill_pos >= DEPTH) ? DEPTH - 1 : fill_pos;
    case (cur_model)
      MODEL_LF_STX:                          closes = (c == CH_LF);
      MODEL_CR_A, MODEL_CR_B, MODEL_CR_FIXED: closes = (c == CH_CR);
      MODEL_ETX_XOR:                         closes = (c == CH_ETX);
      default:                               closes = 1'b0;
    endcase
    shadow_store[p] = c;
    if (!closes) begin
      fill_pos = (p + 1 < DEPTH) ? p + 1 : p;
      return;
    end

    st = ST_OK;
    refresh = 1'b0;
    case (cur_model)
      MODEL_LF_STX: begin
        // CR LF search stops at the first zero byte
        pair = 1'b0;
        for (i = 0; i < p; i++) begin
          if (shadow_store[i] == 8'h00) break;
          if (shadow_store[i] == CH_CR && shadow_store[i + 1] == CH_LF) begin
            pair = 1'b1;
            break;
          end
        end
        if (!pair || shadow_store[0] != CH_STX || p < 12) st = ST_FRAME;
        else void'(load_weight(p - 8, 1'b0));
      end
      MODEL_CR_A, MODEL_CR_B: begin
        if (p < ((cur_model == MODEL_CR_A) ? 5 : 8)) st = ST_FRAME;
        else if (!load_weight(p - ((cur_model == MODEL_CR_A) ? 1 : 3), 1'b1))
          st = ST_BAD_DIGIT;
        else st = confirm_top(refresh);
      end
      MODEL_ETX_XOR: begin
        if (shadow_store[0] != CH_STX || p < 8) begin
          st = ST_FRAME;
        end else begin
          sum = 8'h00;
          for (i = 1; i <= SPAN; i++) sum ^= shadow_store[i];
          got = {shadow_store[p - 2][3:0], shadow_store[p - 1][3:0]};
          if (got != sum) st = ST_CHECKSUM;
          else if (!load_weight(p - 4, 1'b1)) st = ST_BAD_DIGIT;
          else refresh = 1'b1;
        end
      end
      default: begin
        if (p < 7) begin
          st = ST_FRAME;
        end else if (!load_weight(FIXED_TOP_POS, 1'b1)) begin
          st = ST_BAD_DIGIT;
        end else begin
          st = confirm_top(refresh);
          // An accepted fixed-layout frame wipes the store
          if (refresh) for (i = 0; i < DEPTH; i++) shadow_store[i] = 8'h00;
        end
      end
    endcase

    fill_pos = 0;
    res.digit  = {shadow_digit[4], shadow_digit[3], shadow_digit[2], shadow_digit[1],
                  shadow_digit[0]};
    res.upd    = refresh;
    res.status = st;
    pending_q.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one character, hold it until accepted, then predict
  task automatic send_char(input logic [7:0] c);
    // idle cycle by cycle with the sender's odds
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_char(c);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_buf();
    int i;
    for (i = 0; i < frame_buf.size(); i++) send_char(frame_buf[i]);
  endtask

  // Drop valid, wait out every result, then let the block go quiet
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_display_model(input model_t m);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_model = m;
    @(negedge clk);
  endtask

  // Receiver backpressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Frame builders
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] terminator(input model_t m);
    case (m)
      MODEL_LF_STX:  return CH_LF;
      MODEL_ETX_XOR: return CH_ETX;
      default:       return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] printable_char();
    return 8'($urandom_range(126, 32));
  endfunction

  function automatic logic [7:0] non_digit(input model_t m);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while ((c >= CH_ZERO && c <= CH_ZERO + 8'd9) || c == terminator(m));
    return c;
  endfunction

  // Fill frame_buf with one frame of model m; bad_k < 0 keeps all digits valid
  task automatic build_frame(input model_t m, input logic [7:0] top_ch, input int bad_k,
                             input bit bad_sum);
    logic [7:0] dig [5];
    logic [7:0] sum;
    int         i;
    dig[4] = top_ch;
    for (i = 0; i < 4; i++) dig[i] = 8'(CH_ZERO + $urandom_range(9));
    if (bad_k >= 0) dig[bad_k] = non_digit(m);
    frame_buf.delete();

    // Header and filler ahead of the digits
    case (m)
      MODEL_LF_STX: begin
        frame_buf.push_back(CH_STX);
        repeat ($urandom_range(6)) frame_buf.push_back(printable_char());
      end
      MODEL_CR_A:     repeat ($urandom_range(5)) frame_buf.push_back(printable_char());
      MODEL_CR_B:     repeat ($urandom_range(5, 1)) frame_buf.push_back(printable_char());
      MODEL_ETX_XOR: begin
        frame_buf.push_back(CH_STX);
        repeat ($urandom_range(6, 2)) frame_buf.push_back(printable_char());
      end
      default:        repeat (2) frame_buf.push_back(printable_char());
    endcase

    // Digits, most significant first
    for (i = 4; i >= 0; i--) frame_buf.push_back(dig[i]);

    // Trailer up to and including the end character
    case (m)
      MODEL_LF_STX: begin
        repeat (6) frame_buf.push_back(printable_char());
        frame_buf.push_back(CH_CR);
        frame_buf.push_back(CH_LF);
      end
      MODEL_CR_A: frame_buf.push_back(CH_CR);
      MODEL_CR_B: begin
        repeat (2) frame_buf.push_back(printable_char());
        frame_buf.push_back(CH_CR);
      end
      MODEL_ETX_XOR: begin
        frame_buf.push_back(printable_char());
        sum = 8'h00;
        for (i = 1; i <= SPAN; i++) sum ^= frame_buf[i];
        if (bad_sum) sum ^= 8'($urandom_range(255, 1));
        frame_buf.push_back({4'($urandom_range(7, 3)), sum[7:4]});
        frame_buf.push_back({4'($urandom_range(7, 3)), sum[3:0]});
        frame_buf.push_back(CH_ETX);
      end
      default: begin
        repeat ($urandom_range(5)) frame_buf.push_back(printable_char());
        frame_buf.push_back(CH_CR);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_lf_model();
    write_display_model(MODEL_LF_STX);
    build_frame(MODEL_LF_STX, CH_ZERO + 8'd4, -1, 1'b0);
    send_buf();
    // missing start byte
    build_frame(MODEL_LF_STX, CH_ZERO + 8'd4, -1, 1'b0);
    frame_buf[0] = 8'h41;
    send_buf();
    // zero byte ahead of the CR LF pair ends the search
    build_frame(MODEL_LF_STX, CH_ZERO + 8'd4, -1, 1'b0);
    frame_buf[1] = 8'h00;
    send_buf();
    // too short for the digit offsets
    frame_buf = {CH_STX, CH_ZERO, CH_CR, CH_LF};
    send_buf();
  endtask

  task automatic test_cr_models();
    write_display_model(MODEL_CR_A);
    // first frame unsettles the top digit, the repeat refreshes
    repeat (2) begin
      build_frame(MODEL_CR_A, CH_ZERO + 8'd3, -1, 1'b0);
      send_buf();
    end
    build_frame(MODEL_CR_A, CH_ZERO + 8'd3, 2, 1'b0);
    send_buf();
    frame_buf = {CH_ZERO + 8'd1, CH_ZERO + 8'd2, CH_CR};
    send_buf();

    write_display_model(MODEL_CR_B);
    repeat (2) begin
      build_frame(MODEL_CR_B, CH_ZERO + 8'd9, -1, 1'b0);
      send_buf();
    end
    build_frame(MODEL_CR_B, CH_ZERO + 8'd9, 0, 1'b0);
    send_buf();
    frame_buf = {CH_ZERO + 8'd1, CH_CR};
    send_buf();
  endtask

  task automatic test_etx_model();
    write_display_model(MODEL_ETX_XOR);
    build_frame(MODEL_ETX_XOR, CH_ZERO + 8'd7, -1, 1'b0);
    send_buf();
    build_frame(MODEL_ETX_XOR, CH_ZERO + 8'd7, -1, 1'b1);
    send_buf();
    build_frame(MODEL_ETX_XOR, CH_ZERO + 8'd7, 3, 1'b0);
    send_buf();
    build_frame(MODEL_ETX_XOR, CH_ZERO + 8'd7, -1, 1'b0);
    frame_buf[0] = 8'h41;
    send_buf();
    // shortest length: the sum span reaches the end character itself
    frame_buf = {CH_STX, CH_ZERO + 8'd1, CH_ZERO + 8'd2, CH_ZERO + 8'd3, CH_ZERO + 8'd4,
                 CH_ZERO + 8'd5, CH_ZERO + 8'd6, CH_ZERO, CH_ETX};
    send_buf();
    frame_buf = {CH_STX, CH_ZERO, CH_ETX};
    send_buf();
  endtask

  task automatic test_fixed_model();
    write_display_model(MODEL_CR_FIXED);
    // second frame is accepted and clears the store
    repeat (2) begin
      build_frame(MODEL_CR_FIXED, CH_ZERO, -1, 1'b0);
      send_buf();
    end
    build_frame(MODEL_CR_FIXED, CH_ZERO, 4, 1'b0);
    send_buf();
    frame_buf = {CH_ZERO + 8'd1, CH_ZERO + 8'd2, CH_ZERO + 8'd3, CH_CR};
    send_buf();
  endtask

  // Run past the end of the store so the last slot is overwritten
  task automatic test_store_overflow();
    write_display_model(MODEL_CR_A);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(8'h80);
    repeat (40) send_char(8'(CH_ZERO + $urandom_range(9)));
    send_char(CH_CR);
  endtask

  // Mostly well-formed frames, some broken ones and some raw noise
  task automatic run_segment(input model_t m);
    int base;
    int pick;
    int idx;
    int bad_k;
    write_display_model(m);
    base = chars_sent;
    while (chars_sent - base < SEGMENT_CHARS) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        if ($urandom_range(3) == 0) top_pick = 8'(CH_ZERO + $urandom_range(9));
        bad_k = ($urandom_range(9) == 0) ? int'($urandom_range(4)) : -1;
        build_frame(m, top_pick, bad_k, $urandom_range(9) == 0);
        // damage: overwrite or drop one character
        if (pick >= 75) begin
          idx = $urandom_range(frame_buf.size() - 1);
          if ($urandom_range(1) == 1) frame_buf[idx] = 8'($urandom_range(255));
          else frame_buf.delete(idx);
        end
        send_buf();
      end else begin
        repeat ($urandom_range(12, 1)) send_char(8'($urandom_range(255)));
      end
    end
    // close whatever is open before the next model
    send_char(terminator(m));
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 21; recv_idle_pct = 87; end
        1:       begin send_idle_pct = 87; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      run_segment(MODEL_LF_STX);
      run_segment(MODEL_CR_A);
      run_segment(MODEL_CR_B);
      run_segment(MODEL_ETX_XOR);
      run_segment(MODEL_CR_FIXED);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    weight_result_t seen;
    weight_result_t want;
    int             k;
    bit             bad;
    if (rst_n && out_valid && out_ready) begin
      seen.digit  = {out_digit_ten_thousands, out_digit_thousands, out_digit_hundreds,
                     out_digit_tens, out_digit_units};
      seen.upd    = out_update_display;
      seen.status = status_t'(out_frame_status);
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: digits %h update %0b status %0d",
                   seen.digit, seen.upd, seen.status);
      end else begin
        want = pending_q.pop_front();
        bad = (seen.upd != want.upd) || (seen.status != want.status);
        for (k = 0; k < 5; k++)
          if (seen.digit[k] != want.digit[k]) bad = 1'b1;
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch %0d: exp %h/%0b/%0d, got %h/%0b/%0d (digits/update/status)",
                     mismatch_count, want.digit, want.upd, want.status,
                     seen.digit, seen.upd, seen.status);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("tb_top: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_rx_byte  = '0;

    // Shadow state matches the reset values
    for (int i = 0; i < DEPTH; i++) shadow_store[i] = 8'h00;
    for (int i = 0; i < 5; i++) shadow_digit[i] = 4'h0;
    fill_pos       = 0;
    last_top       = 4'h0;
    cur_model      = MODEL_LF_STX;
    top_pick       = CH_ZERO;
    chars_sent     = 0;
    results_seen   = 0;
    mismatch_count = 0;
    send_idle_pct  = 21;
    recv_idle_pct  = 87;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_lf_model();
    test_cr_models();
    test_etx_model();
    test_fixed_model();
    test_store_overflow();
    test_random_traffic();

    drain_results();
    if (pending_q.size() != 0) begin
      $display("%0d predicted results never arrived", pending_q.size());
      mismatch_count += pending_q.size();
    end

    $display("summary: %0d characters, %0d frame results over display models 0 to 4,",
             chars_sent, results_seen);
    $display("summary: three backpressure patterns, %0d mismatches", mismatch_count);
    if (mismatch_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/swfp_pkg.sv
hw/rtl/swfp_store.sv
hw/rtl/swfp_ctrl.sv
hw/rtl/scale_weight_frame_parser.sv
sim/tb_top.sv
